// ===== rtl/rpn_stack_calculator_top_assert.svh =====
// Assertion macros for the RPN stack calculator top level.
`ifndef RPN_STACK_CALCULATOR_TOP_ASSERT_SVH
`define RPN_STACK_CALCULATOR_TOP_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define RSC_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rpn_stack_calculator: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define RSC_ASSERT_NXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rpn_stack_calculator: next-cycle check failed");

`endif

// ===== rtl/rsc_pkg.sv =====
// Shared types and constants of the RPN stack calculator.
package rsc_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W = 3;
   localparam int DEPTH_OUT_W = 5;
   localparam int DIV_CNT_W = 5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
   localparam logic [OP_W-1:0] OP_SUB    = 3'd2;
   localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
   localparam logic [OP_W-1:0] OP_DIV    = 3'd4;
   localparam logic [OP_W-1:0] OP_NEGATE = 3'd5;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_FULL      = 2'd2,
      ST_DIV_ZERO  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_NOP,
      KIND_PUSH,
      KIND_BINARY,
      KIND_NEGATE
   } kind_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_type;

   typedef struct packed {
      kind_type                  kind;
      alu_type                   alu;
      logic signed [DATA_W-1:0]  operand;
   } cmd_type;

   // Queue status: full is seen by the front end, valid by the back end.
   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EXEC,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

// ===== rtl/rsc_front.sv =====
// Front end: takes request transactions and classifies each opcode into a command.
module rsc_front (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_op,
   input  logic signed [31:0]           req_operand,
   input  rsc_pkg::queue_status_type    q_status,
   output logic                         q_push,
   output rsc_pkg::cmd_type             q_cmd
);
   import rsc_pkg::*;

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

   always_comb begin
      q_cmd.operand = req_operand;
      q_cmd.alu     = ALU_ADD;
      q_cmd.kind    = KIND_NOP;
      case (req_op)
         OP_PUSH: begin
            q_cmd.kind = KIND_PUSH;
         end
         OP_ADD: begin
            q_cmd.kind = KIND_BINARY;
            q_cmd.alu  = ALU_ADD;
         end
         OP_SUB: begin
            q_cmd.kind = KIND_BINARY;
            q_cmd.alu  = ALU_SUB;
         end
         OP_MUL: begin
            q_cmd.kind = KIND_BINARY;
            q_cmd.alu  = ALU_MUL;
         end
         OP_DIV: begin
            q_cmd.kind = KIND_BINARY;
            q_cmd.alu  = ALU_DIV;
         end
         OP_NEGATE: begin
            q_cmd.kind = KIND_NEGATE;
         end
         default: begin
            q_cmd.kind = KIND_NOP;
         end
      endcase
   end

endmodule

// ===== rtl/rsc_queue.sv =====
// Two-entry command queue between the front end and the back end.
module rsc_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  rsc_pkg::cmd_type             push_cmd,
   input  logic                         pop,
   output rsc_pkg::queue_status_type    status,
   output rsc_pkg::cmd_type             head_cmd
);
   import rsc_pkg::*;

   cmd_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_cmd     = entry_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/rsc_divider.sv =====
// Restoring unsigned divider that produces one quotient bit per cycle.
module rsc_divider (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [31:0]   dividend,
   input  logic [31:0]   divisor,
   output logic          done,
   output logic [31:0]   quotient
);
   import rsc_pkg::*;

   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DATA_W:0]      trial;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = DIV_CNT_W'(DATA_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

endmodule

// ===== rtl/rsc_back.sv =====
// Back end: operand stack memory, execution sequencer and response register.
module rsc_back #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rsc_pkg::queue_status_type    q_status,
   input  rsc_pkg::cmd_type             q_cmd,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [31:0]           rsp_top_value,
   output logic                         rsp_top_valid,
   output logic [4:0]                   rsp_depth,
   output logic [1:0]                   rsp_status
);
   import rsc_pkg::*;

   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   logic [DATA_W-1:0]       stack_mem [STACK_DEPTH];
   logic [DATA_W-1:0]       rd_top_ff, rd_second_ff;

   back_state_type          state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        new_count_ff, new_count_in;
   logic [DATA_W-1:0]       result_ff, result_in;
   status_type              status_ff, status_in;
   logic                    wr_ff, wr_in;
   logic [IDX_W-1:0]        wr_addr_ff, wr_addr_in;
   logic                    neg_ff, neg_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                    rsp_top_valid_ff, rsp_top_valid_in;
   logic [DEPTH_OUT_W-1:0]  rsp_depth_ff, rsp_depth_in;
   status_type              rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0]        top_pos, second_pos;
   logic [IDX_W-1:0]        top_addr, second_addr;
   logic [DATA_W-1:0]       product;
   logic [DATA_W-1:0]       mag_a, mag_b;
   logic [CNT_W+DEPTH_OUT_W-1:0] depth_wide;
   logic                    out_free, commit, div_start, div_done;
   logic [DATA_W-1:0]       div_quo;

   assign top_pos     = count_ff - 1'b1;
   assign second_pos  = count_ff - CNT_W'(2);
   assign top_addr    = top_pos[IDX_W-1:0];
   assign second_addr = second_pos[IDX_W-1:0];

   // Only the low word of the product is kept, so a 32 by 32 multiplier suffices.
   assign product = rd_second_ff * rd_top_ff;
   assign mag_a   = rd_top_ff[DATA_W-1] ? (DATA_W'(0) - rd_top_ff) : rd_top_ff;
   assign mag_b   = rd_second_ff[DATA_W-1] ? (DATA_W'(0) - rd_second_ff) : rd_second_ff;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign depth_wide = {{DEPTH_OUT_W{1'b0}}, new_count_ff};

   rsc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_b),
      .divisor  (mag_a),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      new_count_in = new_count_ff;
      result_in    = result_ff;
      status_in    = status_ff;
      wr_in        = wr_ff;
      wr_addr_in   = wr_addr_ff;
      neg_in       = neg_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      commit       = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_status.valid) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            state_in     = BK_DONE;
            new_count_in = count_ff;
            result_in    = rd_top_ff;
            status_in    = ST_OK;
            wr_in        = 1'b0;
            wr_addr_in   = top_addr;
            case (q_cmd.kind)
               KIND_PUSH: begin
                  if (count_ff == CNT_W'(STACK_DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     result_in    = q_cmd.operand;
                     wr_in        = 1'b1;
                     wr_addr_in   = count_ff[IDX_W-1:0];
                     new_count_in = count_ff + 1'b1;
                  end
               end
               KIND_BINARY: begin
                  if (count_ff < CNT_W'(2)) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     wr_in        = 1'b1;
                     wr_addr_in   = second_addr;
                     new_count_in = top_pos;
                     case (q_cmd.alu)
                        ALU_ADD: result_in = rd_second_ff + rd_top_ff;
                        ALU_SUB: result_in = rd_second_ff - rd_top_ff;
                        ALU_MUL: result_in = product;
                        ALU_DIV: begin
                           if (rd_top_ff == '0) begin
                              status_in    = ST_DIV_ZERO;
                              wr_in        = 1'b0;
                              new_count_in = count_ff;
                           end else begin
                              neg_in    = rd_top_ff[DATA_W-1] ^ rd_second_ff[DATA_W-1];
                              div_start = 1'b1;
                              state_in  = BK_DIV;
                           end
                        end
                        default: result_in = rd_top_ff;
                     endcase
                  end
               end
               KIND_NEGATE: begin
                  if (count_ff == '0) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     result_in = DATA_W'(0) - rd_top_ff;
                     wr_in     = 1'b1;
                  end
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
         end
         BK_DIV: begin
            if (div_done) begin
               result_in = neg_ff ? (DATA_W'(0) - div_quo) : div_quo;
               state_in  = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               commit   = 1'b1;
               q_pop    = 1'b1;
               count_in = new_count_ff;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_value_in     = rsp_value_ff;
      rsp_top_valid_in = rsp_top_valid_ff;
      rsp_depth_in     = rsp_depth_ff;
      rsp_status_in    = rsp_status_ff;
      if (commit) begin
         rsp_valid_in     = 1'b1;
         rsp_top_valid_in = (new_count_ff != '0);
         rsp_value_in     = (new_count_ff != '0) ? result_ff : '0;
         rsp_depth_in     = depth_wide[DEPTH_OUT_W-1:0];
         rsp_status_in    = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_count_ff     <= new_count_in;
      result_ff        <= result_in;
      status_ff        <= status_in;
      wr_ff            <= wr_in;
      wr_addr_ff       <= wr_addr_in;
      neg_ff           <= neg_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_top_valid_ff <= rsp_top_valid_in;
      rsp_depth_ff     <= rsp_depth_in;
      rsp_status_ff    <= rsp_status_in;
   end

   // Stack memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (commit && wr_ff) begin
         stack_mem[wr_addr_ff] <= result_ff;
      end
      rd_top_ff    <= stack_mem[top_addr];
      rd_second_ff <= stack_mem[second_addr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_value_ff;
   assign rsp_top_valid = rsp_top_valid_ff;
   assign rsp_depth     = rsp_depth_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ===== rtl/rpn_stack_calculator_top.sv =====
// Top level of the RPN stack calculator: front end, command queue and back end.
//
// This block is a postfix integer calculator on an operand stack of STACK_DEPTH
// 32-bit entries. Each request transaction carries one operation (push, add,
// subtract, multiply, divide or negate) and yields exactly one response
// transaction that reports the top of the stack, whether the stack holds any
// entry, the depth and a status code. Errors (underflow, push onto a full stack,
// divide by zero) leave the stack unchanged. A front end classifies each opcode
// and places the command in a two-entry queue, so new requests are taken while
// the back end is busy or a response waits to be taken. The back end runs one
// command at a time: a push, add, subtract, multiply, negate or error case goes
// through the idle, execute and commit states, because the two top entries come
// from a stack memory with registered read ports. A successful divide also waits
// on the radix-2 divider, which produces one quotient bit per cycle.
// The depth field carries the low five bits of the entry count.

`include "rpn_stack_calculator_top_assert.svh"

module rpn_stack_calculator_top #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_op,
   input  logic signed [31:0]   req_operand,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_top_value,
   output logic                 rsp_top_valid,
   output logic [4:0]           rsp_depth,
   output logic [1:0]           rsp_status
);
   import rsc_pkg::*;

   queue_status_type q_status;
   cmd_type          q_push_cmd;
   cmd_type          q_head_cmd;
   logic             q_push;
   logic             q_pop;

   // Opcode classification and request handshake.
   rsc_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_operand (req_operand),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_cmd       (q_push_cmd)
   );

   // Decoupling queue: the front end fills it, the back end drains it.
   rsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .pop      (q_pop),
      .status   (q_status),
      .head_cmd (q_head_cmd)
   );

   // Stack, arithmetic and the response register.
   rsc_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_cmd         (q_head_cmd),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_top_value (rsp_top_value),
      .rsp_top_valid (rsp_top_valid),
      .rsp_depth     (rsp_depth),
      .rsp_status    (rsp_status)
   );

   // A completed command always loads the response register.
   `RSC_ASSERT_NXT(a_pop_gives_response, clock, reset, q_pop, rsp_valid)
   // A divide by zero leaves the zero divisor on top of the stack.
   `RSC_ASSERT_IMP(a_div_zero_top, clock, reset, rsp_valid && (rsp_status == ST_DIV_ZERO), rsp_top_valid && (rsp_top_value == 32'sd0))
   // Only a non-empty stack can be full.
   `RSC_ASSERT_IMP(a_full_has_top, clock, reset, rsp_valid && (rsp_status == ST_FULL), rsp_top_valid)
   // Underflow only happens with fewer than two entries.
   `RSC_ASSERT_IMP(a_underflow_depth, clock, reset, rsp_valid && (rsp_status == ST_UNDERFLOW), rsp_depth <= 5'd1)

endmodule

// ===== verif/rpn_stack_calculator_checker.sv =====
// Checker for the RPN stack calculator: tracks the operand stack and checks every response.
module rpn_stack_calculator_checker #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [2:0]          req_op,
   input  logic signed [31:0]  req_operand,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic signed [31:0]  rsp_top_value,
   input  logic                rsp_top_valid,
   input  logic [4:0]          rsp_depth,
   input  logic [1:0]          rsp_status,
   output int                  mismatch_count,
   output int                  reports_outstanding
);
   import rsc_pkg::*;

   typedef struct {
      logic [31:0] top_value;
      logic        top_valid;
      logic [4:0]  depth;
      status_type  status;
   } stack_report_type;

   logic [31:0]      operand_stack [STACK_DEPTH];
   int unsigned      stack_count = 0;
   stack_report_type stack_reports [$];
   int               responses_seen = 0;

   initial mismatch_count = 0;
   initial reports_outstanding = 0;

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s in response %0d: got %h, expected %h",
               field, responses_seen, got, want);
      mismatch_count++;
   endtask

   // Signed division truncated toward zero, done on magnitudes so that the most
   // negative value divided by minus one wraps instead of trapping.
   function automatic logic [31:0] quotient_toward_zero(input logic [31:0] dividend,
                                                        input logic [31:0] divisor);
      logic [31:0] mag_n;
      logic [31:0] mag_d;
      logic [31:0] quot;
      mag_n = dividend[31] ? -dividend : dividend;
      mag_d = divisor[31] ? -divisor : divisor;
      quot = mag_n / mag_d;
      return (dividend[31] != divisor[31]) ? -quot : quot;
   endfunction

   function automatic stack_report_type step_stack(input logic [2:0] op,
                                                   input logic [31:0] operand);
      stack_report_type rep;
      logic [31:0]      a;
      logic [31:0]      b;
      logic [31:0]      r;
      rep.status = ST_OK;
      case (op)
         OP_PUSH: begin
            if (stack_count >= STACK_DEPTH) begin
               rep.status = ST_FULL;
            end else begin
               operand_stack[stack_count] = operand;
               stack_count++;
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (stack_count < 2) begin
               rep.status = ST_UNDERFLOW;
            end else begin
               a = operand_stack[stack_count - 1];
               b = operand_stack[stack_count - 2];
               if (op == OP_DIV && a == '0) begin
                  rep.status = ST_DIV_ZERO;
               end else begin
                  case (op)
                     OP_ADD:  r = b + a;
                     OP_SUB:  r = b - a;
                     OP_MUL:  r = b * a;
                     default: r = quotient_toward_zero(b, a);
                  endcase
                  stack_count--;
                  operand_stack[stack_count - 1] = r;
               end
            end
         end
         OP_NEGATE: begin
            if (stack_count == 0)
               rep.status = ST_UNDERFLOW;
            else
               operand_stack[stack_count - 1] = -operand_stack[stack_count - 1];
         end
         default: ;
      endcase
      rep.top_valid = (stack_count != 0);
      if (rep.top_valid)
         rep.top_value = operand_stack[stack_count - 1];
      else
         rep.top_value = '0;
      rep.depth = 5'(stack_count);
      return rep;
   endfunction

   // Responses are retired before the request of the same edge is applied, so a
   // response can never be matched against a prediction made in its own cycle.
   always @(posedge clock) begin : watch_channels
      stack_report_type want;
      if (reset) begin
         stack_count = 0;
         stack_reports.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (stack_reports.size() == 0) begin
               report_mismatch("unexpected response", rsp_top_value, '0);
            end else begin
               want = stack_reports.pop_front();
               if (rsp_top_value !== want.top_value)
                  report_mismatch("top_value", rsp_top_value, want.top_value);
               if (rsp_top_valid !== want.top_valid)
                  report_mismatch("top_valid", 32'(rsp_top_valid), 32'(want.top_valid));
               if (rsp_depth !== want.depth)
                  report_mismatch("depth", 32'(rsp_depth), 32'(want.depth));
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
            end
            responses_seen++;
         end
         if (req_valid && !req_stall)
            stack_reports.push_back(step_stack(req_op, req_operand));
      end
      reports_outstanding <= stack_reports.size();
   end

endmodule

// ===== verif/rpn_stack_calculator_top_test.sv =====
// Testbench top for the RPN stack calculator: stimulus, stall control, watchdog and verdict.
module rpn_stack_calculator_top_test;
   import rsc_pkg::*;

   localparam int STACK_DEPTH = 16;

   // The random part runs in three idling phases of at least this many operations each.
   localparam int PHASE_ITEMS = 217;

   // A successful divide is the slowest command; the drain wait covers it with
   // some margin.
   localparam int DRAIN_CYCLES = 48;

   // Long receiver hold-off that lets the command queue fill and back up.
   localparam int HOLD_OFF_CYCLES = 80;

   // Cycles without any transaction on either channel before the run is abandoned.
   localparam int QUIET_LIMIT = 4000;

   // Opcodes the block does not define; it must leave the stack alone.
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam logic [31:0] MOST_NEG  = 32'h8000_0000;
   localparam logic [31:0] MOST_POS  = 32'h7fff_ffff;
   localparam logic [31:0] MINUS_ONE = 32'hffff_ffff;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_op = OP_PUSH;
   logic signed [31:0] req_operand = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_top_value;
   logic               rsp_top_valid;
   logic [4:0]         rsp_depth;
   logic [1:0]         rsp_status;

   int                 mismatch_count;
   int                 reports_outstanding;

   // Idle percentages of the two sides; these first-phase values hold from time zero.
   int unsigned        req_idle_pct = 34;
   int unsigned        rsp_idle_pct = 58;

   logic               hold_wanted = 1'b0;
   int unsigned        hold_left = 0;
   int unsigned        quiet_cycles = 0;

   // Count of defined operations sent; spare opcodes are not counted.
   int                 ops_sent = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   rpn_stack_calculator_top #(
      .STACK_DEPTH(STACK_DEPTH)
   ) dut (.*);

   rpn_stack_calculator_checker #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_checker (.*);

   // Receiver side. A requested hold-off keeps stall high until its hold count
   // runs out, no matter what the idle percentage is; otherwise stall is drawn
   // fresh every cycle.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_wanted) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_OFF_CYCLES;
         hold_wanted <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Watchdog: any transaction on either channel restarts the count.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Offers one operation and returns at the edge where it was accepted. Any
   // idle gap comes before the offer, so once valid is raised it stays up and
   // the payload holds still until the block takes it.
   task automatic offer(input logic [2:0] op, input logic [31:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_operand <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (op <= OP_NEGATE)
         ops_sent++;
   endtask

   // Push values lean toward small numbers and zero so that divides by zero and
   // sign corner cases come up often; the rest covers the whole 32-bit range.
   function automatic logic [31:0] pick_operand();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 30)
         return $urandom_range(16) - 8;
      else if (pick < 40)
         return '0;
      else if (pick < 55) begin
         case ($urandom_range(4))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return MINUS_ONE;
            3:       return 32'd1;
            default: return MOST_NEG + 1;
         endcase
      end
      return $urandom();
   endfunction

   function automatic logic [2:0] pick_arith_op();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 25)
         return OP_ADD;
      else if (pick < 45)
         return OP_SUB;
      else if (pick < 65)
         return OP_MUL;
      else if (pick < 90)
         return OP_DIV;
      return OP_NEGATE;
   endfunction

   // Random traffic. Most of it is short postfix expressions: a few pushes
   // followed by about as many operations, which keeps the depth wandering
   // through the middle of the stack. Push bursts drive the stack to full,
   // operation bursts drain it into underflow, and a small share is noise with
   // any opcode at all, the spare ones included.
   task automatic run_random(input int count);
      int          start;
      int unsigned pick;
      int unsigned pushes;
      start = ops_sent;
      while (ops_sent - start < count) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            pushes = $urandom_range(4, 1);
            repeat (pushes)
               offer(OP_PUSH, pick_operand());
            repeat ($urandom_range(pushes + 1, pushes - 1))
               offer(pick_arith_op(), $urandom());
         end else if (pick < 80) begin
            repeat ($urandom_range(18, 14))
               offer(OP_PUSH, pick_operand());
         end else if (pick < 90) begin
            repeat ($urandom_range(18, 6))
               offer(pick_arith_op(), $urandom());
         end else begin
            offer(3'($urandom_range(7)), $urandom());
         end
      end
   endtask

   initial begin
      repeat (3)
         @(posedge clock);
      reset <= 1'b0;

      // Directed opening. On the empty stack: a binary operation and a negate
      // both underflow, and the spare opcodes are ignored.
      offer(OP_ADD, $urandom());
      offer(OP_NEGATE, $urandom());
      offer(OP_SPARE_6, $urandom());
      offer(OP_SPARE_7, $urandom());

      // Fill the stack to the limit with the most positive value at the bottom
      // and the most negative value, minus one and zero on top; one more push
      // must report a full stack.
      offer(OP_PUSH, MOST_POS);
      repeat (STACK_DEPTH - 4)
         offer(OP_PUSH, $urandom());
      offer(OP_PUSH, MOST_NEG);
      offer(OP_PUSH, MINUS_ONE);
      offer(OP_PUSH, '0);
      offer(OP_PUSH, $urandom());

      // Divide by the zero on top fails and leaves the stack alone. Subtracting
      // the zero leaves minus one on top; the most negative value divided by
      // minus one then wraps, and negating the result wraps again.
      offer(OP_DIV, $urandom());
      offer(OP_SUB, $urandom());
      offer(OP_DIV, $urandom());
      offer(OP_NEGATE, $urandom());

      // First phase: sender idles a third of the time, receiver more than half.
      run_random(PHASE_ITEMS);

      // Second phase: the two sides swap their idle rates.
      req_idle_pct = 58;
      rsp_idle_pct <= 34;
      run_random(PHASE_ITEMS);

      // Third phase: nobody idles, apart from one long receiver hold-off at the
      // start while the sender keeps offering, so the queue fills and the block
      // has to stall its input.
      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      hold_wanted <= 1'b1;
      run_random(PHASE_ITEMS);

      req_valid <= 1'b0;

      // The outstanding count is registered in the checker, so the test waits for
      // the next edge before it reads the count.
      @(posedge clock);
      while (reports_outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
